### rtl/nrf_pkg.sv
// ---------------------------------------------------------------------------
// nrf_pkg
// Shared types, codes and constants of the receive address filter and
// ring page allocator.
// ---------------------------------------------------------------------------
package nrf_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int HASH_OCTETS = 6;
   localparam int HASH_SHIFT  = 26;
   localparam int HDR_BYTES   = 4;
   localparam int PAGE_ROUND  = 255;

   localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
   localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;
   localparam logic [7:0]  RSR_PRX    = 8'h01;
   localparam logic [7:0]  RSR_MPA    = 8'h10;
   localparam logic [7:0]  RSR_PHY    = 8'h20;

   typedef struct packed {
      logic [47:0] dest_address;
      logic [13:0] frame_length;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  outcome;
      logic [7:0]  write_page;
      logic [7:0]  next_pkt_page;
      logic [7:0]  header_status;
      logic [15:0] byte_count;
      logic        missed_pulse;
      logic        irq_received;
      logic        irq_overflow;
      logic [7:0]  receive_status;
   } rsp_type;

   typedef enum logic [2:0] {
      OUT_STORED    = 3'd0,
      OUT_DISABLED  = 3'd1,
      OUT_REJECTED  = 3'd2,
      OUT_MONITORED = 3'd3,
      OUT_OVERFLOW  = 3'd4,
      OUT_GEOMETRY  = 3'd5
   } outcome_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RECEIVE_MODE      = 3'd0,
      CSR_ENGINE_GATE       = 3'd1,
      CSR_MULTICAST_TABLE   = 3'd2,
      CSR_STATION_ADDRESS   = 3'd3,
      CSR_RING_START_PAGE   = 3'd4,
      CSR_RING_STOP_PAGE    = 3'd5,
      CSR_BOUNDARY_PAGE     = 3'd6,
      CSR_CURRENT_PAGE_LOAD = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  receive_mode;
      logic [2:0]  engine_gate;
      logic [63:0] multicast_table;
      logic [47:0] station_address;
      logic [7:0]  ring_start_page;
      logic [7:0]  ring_stop_page;
      logic [7:0]  boundary_page;
      logic        page_load;
      logic [7:0]  page_load_value;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_EVAL,
      ST_WALK,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic eval;
      logic walk_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic hash_last;
      logic walk_needed;
      logic walk_end;
      logic ovf_latched;
   } dp_sts_type;

   // One octet of the reflected-input CRC-32, least significant bit first.
   function automatic logic [31:0] crc_octet(input logic [31:0] crc,
                                             input logic [7:0]  octet);
      logic [31:0] c;
      logic        feed;
      c = crc;
      for (int b = 0; b < 8; b++) begin
         feed = c[31] ^ octet[b];
         c    = {c[30:0], 1'b0} ^ (feed ? CRC_POLY : 32'h0);
      end
      return c;
   endfunction

endpackage

### rtl/nrf_csr.sv
// ---------------------------------------------------------------------------
// nrf_csr
// Configuration register file; a write to the current page load register
// issues a one-cycle load toward the datapath.
// ---------------------------------------------------------------------------
module nrf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [nrf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nrf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output nrf_pkg::cfg_type                    cfg
);
   import nrf_pkg::*;

   logic [3:0]  receive_mode_ff;
   logic [2:0]  engine_gate_ff;
   logic [63:0] multicast_table_ff;
   logic [47:0] station_address_ff;
   logic [7:0]  ring_start_page_ff;
   logic [7:0]  ring_stop_page_ff;
   logic [7:0]  boundary_page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         receive_mode_ff    <= '0;
         engine_gate_ff     <= 3'd1;
         multicast_table_ff <= '0;
         station_address_ff <= '0;
         ring_start_page_ff <= '0;
         ring_stop_page_ff  <= '0;
         boundary_page_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RECEIVE_MODE:    receive_mode_ff    <= csr_wdata[3:0];
            CSR_ENGINE_GATE:     engine_gate_ff     <= csr_wdata[2:0];
            CSR_MULTICAST_TABLE: multicast_table_ff <= csr_wdata[63:0];
            CSR_STATION_ADDRESS: station_address_ff <= csr_wdata[47:0];
            CSR_RING_START_PAGE: ring_start_page_ff <= csr_wdata[7:0];
            CSR_RING_STOP_PAGE:  ring_stop_page_ff  <= csr_wdata[7:0];
            CSR_BOUNDARY_PAGE:   boundary_page_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.receive_mode    = receive_mode_ff;
      cfg.engine_gate     = engine_gate_ff;
      cfg.multicast_table = multicast_table_ff;
      cfg.station_address = station_address_ff;
      cfg.ring_start_page = ring_start_page_ff;
      cfg.ring_stop_page  = ring_stop_page_ff;
      cfg.boundary_page   = boundary_page_ff;
      cfg.page_load       = csr_we &&
                            (csr_index_type'(csr_index) == CSR_CURRENT_PAGE_LOAD);
      cfg.page_load_value = csr_wdata[7:0];
   end

endmodule

### rtl/nrf_ctrl.sv
// ---------------------------------------------------------------------------
// nrf_ctrl
// Sequencer: accept a frame beat, run the hash octets, evaluate, walk the
// linked pages when a stored frame spans more than one, then commit into the result register.
// ---------------------------------------------------------------------------
module nrf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nrf_pkg::dp_cmd_type   cmd,
   input  nrf_pkg::dp_sts_type   sts
);
   import nrf_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.walk_needed ? ST_WALK : ST_FINISH;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register is free or drains this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/nrf_dp.sv
// ---------------------------------------------------------------------------
// nrf_dp
// Datapath: address hash, filter and ring checks, page link walker, ring
// state and the result register.
// ---------------------------------------------------------------------------
module nrf_dp #(
   parameter int RAM_BASE_PAGE = 64,
   parameter int RAM_PAGES     = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nrf_pkg::cfg_type      cfg,
   input  nrf_pkg::req_type      req_data,
   input  nrf_pkg::dp_cmd_type   cmd,
   output nrf_pkg::dp_sts_type   sts,
   output nrf_pkg::rsp_type      rsp_data
);
   import nrf_pkg::*;

   localparam logic [8:0] PMIN = 9'(RAM_BASE_PAGE);
   localparam logic [8:0] PMAX = 9'(RAM_BASE_PAGE + RAM_PAGES);

   logic [47:0] addr_ff;
   logic [13:0] len_ff;
   logic [47:0] shift_ff;
   logic [31:0] crc_ff;
   logic [2:0]  hash_cnt_ff;
   logic [2:0]  outcome_ff;
   logic [7:0]  link_ff;
   logic [6:0]  walk_left_ff;
   logic [7:0]  current_page_ff;
   logic [7:0]  status_ff;
   logic        ovf_latched_ff;
   rsp_type     rsp_ff;

   logic        gate_off, group, addr_pass;
   logic [5:0]  hash;
   logic [8:0]  pstart9, pstop9, cur9, ring_size9;
   logic        geom_bad, too_big;
   logic [14:0] total, rounded;
   logic [6:0]  pages;
   logic [2:0]  eval_outcome;
   logic [8:0]  link_inc9;
   logic [7:0]  link_nxt;
   logic        hit;
   logic [8:0]  next9, npage9;
   logic [7:0]  hstat, status_new;
   rsp_type     rsp_in;

   // evaluation of the captured frame
   always_comb begin
      gate_off = cfg.engine_gate[0] | ~cfg.engine_gate[1] | cfg.engine_gate[2];
      group    = addr_ff[40];
      hash     = crc_ff[31:HASH_SHIFT];
      if (addr_ff == BCAST_ADDR)
         addr_pass = cfg.receive_mode[0];
      else if (group)
         addr_pass = cfg.receive_mode[1] & cfg.multicast_table[hash];
      else
         addr_pass = cfg.receive_mode[2] | (addr_ff == cfg.station_address);

      pstart9    = {1'b0, cfg.ring_start_page};
      pstop9     = {1'b0, cfg.ring_stop_page};
      cur9       = {1'b0, current_page_ff};
      ring_size9 = pstop9 - pstart9;
      geom_bad   = (pstart9 < PMIN) || (pstart9 >= PMAX) || (pstop9 < PMIN) ||
                   (pstop9 > PMAX) || (pstart9 >= pstop9) ||
                   (cur9 < pstart9) || (cur9 >= pstop9);

      total   = {1'b0, len_ff} + 15'(HDR_BYTES);
      rounded = total + 15'(PAGE_ROUND);
      pages   = rounded[14:8];
      too_big = {2'b00, pages} >= ring_size9;

      if (gate_off)                 eval_outcome = OUT_DISABLED;
      else if (!addr_pass)          eval_outcome = OUT_REJECTED;
      else if (cfg.receive_mode[3]) eval_outcome = OUT_MONITORED;
      else if (geom_bad)            eval_outcome = OUT_GEOMETRY;
      else if (too_big)             eval_outcome = OUT_OVERFLOW;
      else                          eval_outcome = OUT_STORED;

      // one link of the page walk
      link_inc9 = {1'b0, link_ff} + 9'd1;
      link_nxt  = (link_inc9 >= pstop9) ? cfg.ring_start_page : link_inc9[7:0];
      hit       = (link_nxt == cfg.boundary_page);

      sts.hash_last   = (hash_cnt_ff == 3'(HASH_OCTETS - 1));
      sts.walk_needed = (eval_outcome == OUT_STORED) && (pages > 7'd1);
      sts.walk_end    = hit || (walk_left_ff == 7'd1);
      sts.ovf_latched = ovf_latched_ff;
   end

   // result and state update at commit
   always_comb begin
      next9  = cur9 + {2'b00, pages};
      npage9 = (next9 >= pstop9) ? pstart9 + (next9 - pstop9) : next9;
      hstat  = RSR_PRX | (group ? RSR_PHY : 8'h00);

      rsp_in         = '0;
      rsp_in.outcome = outcome_ff;
      status_new     = status_ff;
      case (outcome_type'(outcome_ff))
         OUT_STORED: begin
            rsp_in.accepted      = 1'b1;
            rsp_in.write_page    = current_page_ff;
            rsp_in.next_pkt_page = npage9[7:0];
            rsp_in.header_status = hstat;
            rsp_in.byte_count    = 16'(total);
            rsp_in.irq_received  = 1'b1;
            status_new           = hstat;
         end
         OUT_MONITORED: begin
            rsp_in.missed_pulse = 1'b1;
            status_new          = status_ff | RSR_MPA;
         end
         OUT_OVERFLOW: begin
            rsp_in.missed_pulse = 1'b1;
            rsp_in.irq_overflow = 1'b1;
            status_new          = status_ff | RSR_MPA;
         end
         default: ;
      endcase
      rsp_in.receive_status = status_new;
   end

   // frame working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff     <= req_data.dest_address;
         len_ff      <= req_data.frame_length;
         shift_ff    <= req_data.dest_address;
         crc_ff      <= CRC_INIT;
         hash_cnt_ff <= '0;
      end
      if (cmd.hash_step) begin
         // advance one octet, first octet of the address first
         crc_ff      <= crc_octet(crc_ff, shift_ff[47:40]);
         shift_ff    <= {shift_ff[39:0], 8'h00};
         hash_cnt_ff <= hash_cnt_ff + 3'd1;
      end
      if (cmd.eval) begin
         outcome_ff   <= eval_outcome;
         link_ff      <= current_page_ff;
         walk_left_ff <= pages - 7'd1;
      end
      if (cmd.walk_step) begin
         link_ff      <= link_nxt;
         walk_left_ff <= walk_left_ff - 7'd1;
         if (hit) outcome_ff <= OUT_OVERFLOW;
      end
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   // ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         current_page_ff <= '0;
         status_ff       <= '0;
         ovf_latched_ff  <= 1'b0;
      end else begin
         if (cfg.page_load) current_page_ff <= cfg.page_load_value;
         if (cmd.commit) begin
            status_ff <= status_new;
            if (outcome_type'(outcome_ff) == OUT_STORED) current_page_ff <= npage9[7:0];
            if (outcome_type'(outcome_ff) == OUT_OVERFLOW) ovf_latched_ff <= 1'b1;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/nic_receive_filter_ring_core.sv
// ---------------------------------------------------------------------------
// nic_receive_filter_ring_core
// Receive address filter and ring page allocator: gate, hash/station
// filter, ring checks, boundary walk and current page advance per frame.
//
//   channel | ports                          | direction | beat
//   req     | req_valid req_ready req_data   | in        | one frame descriptor
//   rsp     | rsp_valid rsp_ready rsp_data   | out       | one verdict per frame
//   csr     | csr_we csr_index csr_wdata     | in        | one register write
//
// One frame at a time: an accept step, six hash steps (one address octet of
// the CRC per cycle), an evaluate step, then one page walker step per linked
// page after the first (pages - 1, at most 62 with the default 64-page ring),
// then a commit step.
// Reset is synchronous and clears the sequencer, ring state and configuration registers.
// A stalled result holds in the output register; a new frame is accepted
// while it waits, and commit waits only if the previous beat is still there.
// ---------------------------------------------------------------------------
module nic_receive_filter_ring_core #(
   parameter int RAM_BASE_PAGE = 64,
   parameter int RAM_PAGES     = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  nrf_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output nrf_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [nrf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nrf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nrf_pkg::*;

   cfg_type    cfg;
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   nrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   nrf_dp #(
      .RAM_BASE_PAGE (RAM_BASE_PAGE),
      .RAM_PAGES     (RAM_PAGES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (dp_cmd),
      .sts      (dp_sts),
      .rsp_data (rsp_data)
   );

   // a frame in work blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high in the cycle after an accepted frame");

   // a result appears only after the sequencer left idle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without a frame in work");

   // the overflow latch sets together with an overflow verdict
   a_overflow_latch: assert property (@(posedge clock) disable iff (reset)
      $rose(dp_sts.ovf_latched) |-> rsp_valid && rsp_data.irq_overflow &&
         (rsp_data.outcome == OUT_OVERFLOW))
      else $error("overflow latch set without an overflow result");

   // a stored frame raises the received pulse and never the missed pulse
   a_stored_pages: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_data.accepted |->
         rsp_data.irq_received && !rsp_data.missed_pulse)
      else $error("stored result carries inconsistent pulses");

endmodule
